>>> hdl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 10;
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_SLOT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   entity_id;
        logic [DATA_W-1:0] payload_in;
        logic [SLOT_W-1:0] slot_index;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   payload_out;
        logic [ID_W-1:0]     owner_out;
        logic [COUNT_W-1:0]  member_count;
    } rsp_item_t;

endpackage

>>> hdl/sst_if.sv
`timescale 1ns / 1ps

interface sst_req_if;
    logic               valid;
    logic               ready;
    sst_pkg::req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface sst_rsp_if;
    logic               valid;
    logic               ready;
    sst_pkg::rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> hdl/sst_ram.sv
`timescale 1ns / 1ps

module sst_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds its value between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sparse_set_table_top.sv
`timescale 1ns / 1ps

// channel  side  beat contents
// req      in    command, entity_id, payload_in, slot_index
// rsp      out   status, payload_out, owner_out, member_count
//
// each command reads the sparse map on the accept edge, then the dense array at the mapped
// slot in S_CHECK, then checks membership and writes back in S_EVAL; the dependent
// sparse-then-dense read through memories with a registered read sets these steps
// after reset a sweep over all MAX_ENTITIES entries zeroes the sparse map; req.ready stays low
// the result waits in an output register; a new command is taken meanwhile and its
// last step holds until that register is free

module sparse_set_table_top #(
    parameter int MAX_ENTITIES  = 1024,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);

    localparam int IDX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam int PW    = PAYLOAD_WIDTH;
    localparam int ENT_W = IDX_W + PW;
    localparam int DW    = sst_pkg::DATA_W;
    localparam int OW    = sst_pkg::ID_W;
    localparam int MCW   = sst_pkg::COUNT_W;
    localparam logic [31:0] MAX_U  = 32'(MAX_ENTITIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTITIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_EVAL
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              clr_idx_reg, clr_idx_next;
    logic [sst_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [sst_pkg::ID_W-1:0]      id_reg, id_next;
    logic [PW-1:0]                 pay_reg, pay_next;
    logic [sst_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ENT_W-1:0]              last_reg, last_next;
    logic                          out_valid_reg, out_valid_next;
    sst_pkg::rsp_item_t            out_item_reg, out_item_next;

    logic                 sparse_we, sparse_re;
    logic [IDX_W-1:0]     sparse_waddr, sparse_raddr, sparse_wdata, sparse_rdata;
    logic                 dense_we, dense_re;
    logic [IDX_W-1:0]     dense_waddr, dense_raddr;
    logic [ENT_W-1:0]     dense_wdata, dense_rdata;

    logic                 accept;
    logic                 fin;
    logic                 id_ok;
    logic                 member;
    logic                 full;
    logic                 slot_ok;
    logic [IDX_W-1:0]     hole;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     moved_owner;
    sst_pkg::rsp_item_t   result;

    sst_ram #(
        .DEPTH (MAX_ENTITIES),
        .WIDTH (IDX_W)
    ) u_sparse (
        .clk   (clk),
        .we    (sparse_we),
        .waddr (sparse_waddr),
        .wdata (sparse_wdata),
        .re    (sparse_re),
        .raddr (sparse_raddr),
        .rdata (sparse_rdata)
    );

    // dense entry: owner id above payload
    sst_ram #(
        .DEPTH (MAX_ENTITIES),
        .WIDTH (ENT_W)
    ) u_dense (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .re    (dense_re),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fin       = (state_reg == S_EVAL) && (!out_valid_reg || rsp.ready);

    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    // membership: id in range, mapped slot below count and owner at that slot matches
    assign hole        = sparse_rdata;
    assign last_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign moved_owner = last_reg[ENT_W-1 -: IDX_W];
    assign id_ok       = 32'(id_reg) < MAX_U;
    assign member      = id_ok && (32'(hole) < 32'(count_reg))
                         && (32'(dense_rdata[ENT_W-1 -: IDX_W]) == 32'(id_reg));
    assign full        = 32'(count_reg) >= MAX_U;
    assign slot_ok     = 32'(slot_reg) < 32'(count_reg);

    always_comb
    begin
        sparse_re    = 1'b0;
        sparse_raddr = IDX_W'(req.item.entity_id);
        dense_re     = 1'b0;
        dense_raddr  = last_idx;
        sparse_we    = 1'b0;
        sparse_waddr = clr_idx_reg;
        sparse_wdata = '0;
        dense_we     = 1'b0;
        dense_waddr  = hole;
        dense_wdata  = last_reg;
        count_next   = count_reg;
        result.status       = sst_pkg::ST_OK;
        result.payload_out  = '0;
        result.owner_out    = '0;
        result.member_count = '0;

        if (state_reg == S_CLEAR)
        begin
            sparse_we = 1'b1;
        end

        if (accept)
        begin
            sparse_re = 1'b1;
            dense_re  = 1'b1;
            if (req.item.command == sst_pkg::CMD_READ_SLOT)
            begin
                dense_raddr = IDX_W'(req.item.slot_index);
            end
        end

        if (state_reg == S_CHECK)
        begin
            dense_re    = 1'b1;
            dense_raddr = hole;
        end

        if (state_reg == S_EVAL)
        begin
            case (cmd_reg)
                sst_pkg::CMD_INSERT:
                begin
                    result.owner_out = id_reg;
                    if (!id_ok || member)
                    begin
                        result.status = sst_pkg::ST_ABSENT;
                    end
                    else if (full)
                    begin
                        result.status = sst_pkg::ST_FULL;
                    end
                    else
                    begin
                        sparse_we    = fin;
                        sparse_waddr = IDX_W'(id_reg);
                        sparse_wdata = IDX_W'(count_reg);
                        dense_we     = fin;
                        dense_waddr  = IDX_W'(count_reg);
                        dense_wdata  = {IDX_W'(id_reg), pay_reg};
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                sst_pkg::CMD_REMOVE:
                begin
                    result.owner_out = id_reg;
                    if (!member)
                    begin
                        result.status = sst_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        // last member moves into the hole
                        if (hole != last_idx)
                        begin
                            dense_we     = fin;
                            dense_waddr  = hole;
                            dense_wdata  = last_reg;
                            sparse_we    = fin;
                            sparse_waddr = moved_owner;
                            sparse_wdata = hole;
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                sst_pkg::CMD_LOOKUP:
                begin
                    result.owner_out = id_reg;
                    if (!member)
                    begin
                        result.status = sst_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        result.payload_out = DW'(dense_rdata[PW-1:0]);
                    end
                end
                sst_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                sst_pkg::CMD_READ_SLOT:
                begin
                    if (!slot_ok)
                    begin
                        result.status = sst_pkg::ST_RANGE;
                    end
                    else
                    begin
                        result.payload_out = DW'(last_reg[PW-1:0]);
                        result.owner_out   = OW'(moved_owner);
                    end
                end
                default:
                begin
                    result.status = sst_pkg::ST_OK;
                end
            endcase
            result.member_count = MCW'(count_next);
            if (!fin)
            begin
                count_next = count_reg;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        pay_next       = pay_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.item.command;
                    id_next    = req.item.entity_id;
                    pay_next   = PW'(req.item.payload_in);
                    slot_next  = req.item.slot_index;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // keep the last or addressed entry; the port now reads the mapped slot
                last_next  = dense_rdata;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (fin)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = result;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            cmd_reg       <= '0;
            id_reg        <= '0;
            pay_reg       <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            pay_reg       <= pay_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_U)
        else $error("member count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && (cmd_reg == sst_pkg::CMD_INSERT) && (result.status == sst_pkg::ST_OK))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("successful insert did not grow the set");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        (sparse_we || dense_we) |-> ((state_reg == S_EVAL) || (state_reg == S_CLEAR)))
        else $error("memory write outside the write-back step");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && (cmd_reg == sst_pkg::CMD_REMOVE) && (result.status == sst_pkg::ST_OK))
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("successful remove did not shrink the set");

endmodule
